### hdl/assert_macros.svh
// Assertion macros shared by the Chebyshev evaluator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CSE_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hdl/cse_pkg.sv
// Package with types, widths and constants of the Chebyshev series evaluator.
package cse_pkg;

  // Table sizes
  localparam int MAX_TERMS   = 32;
  localparam int MAX_DIMS    = 4;
  localparam int STORE_DEPTH = MAX_DIMS * MAX_TERMS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int TCNT_W      = $clog2(MAX_TERMS + 1);
  localparam int DCNT_W      = $clog2(MAX_DIMS + 1);

  // Field widths
  localparam int NUM_TERMS_W = 6;
  localparam int NUM_DIMS_W  = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;
  localparam int DIM_W       = 2;
  localparam int TERM_W      = 5;
  localparam int COEFF_W     = 48;
  localparam int X_W         = 32;
  localparam int FRAC_W      = 30;

  // Datapath widths
  localparam int HALF_W  = 16;                    // split of |T| for the coefficient product
  localparam int TWP_W   = 2 * X_W - 1;           // |x| * |T|
  localparam int TWM_W   = TWP_W - (FRAC_W - 1);  // rounded magnitude of 2xT
  localparam int TW_W    = TWM_W + 2;             // signed 2xT - T
  localparam int PROD_W  = COEFF_W + X_W;         // |c| * |T|
  localparam int Q_W     = PROD_W - FRAC_W;       // rounded magnitude of c*T
  localparam int ACC_W   = 57;                    // exact running sum

  // Request queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One in Q1.30
  localparam logic signed [X_W-1:0] X_ONE     = X_W'(2 ** FRAC_W);
  localparam logic signed [X_W-1:0] X_NEG_ONE = -X_ONE;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TERMS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS  = CFG_IDX_W'(1);

  // Commands
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  // Request passed from the front end to the evaluator
  typedef struct packed {
    logic                       is_eval;
    logic [ADDR_W-1:0]          addr;
    logic signed [COEFF_W-1:0]  coeff;
    logic signed [X_W-1:0]      x;
  } cse_req_t;

  // Effective configuration seen by the evaluator
  typedef struct packed {
    logic [TCNT_W-1:0] nt;
    logic [DCNT_W-1:0] nd;
  } cse_cfg_t;

endpackage

### hdl/cse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cse_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry when enabled, read one entry every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/cse_front.sv
// Front end: accepts requests, drops loads outside the table, forms addresses, clamps x.
module cse_front import cse_pkg::*; (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [DIM_W-1:0]          dim_select_i,
  input  logic [TERM_W-1:0]         term_select_i,
  input  logic signed [COEFF_W-1:0] coeff_value_i,
  input  logic signed [X_W-1:0]     x_value_i,
  output logic                      push_o,
  output cse_req_t                  req_o,
  input  logic                      q_ready_i
);

  logic is_eval;
  logic in_table;

  // Classify the request
  assign is_eval  = (command_i == CMD_EVAL);
  assign in_table = (int'(dim_select_i) < MAX_DIMS) && (int'(term_select_i) < MAX_TERMS);

  // Take a request whenever the queue has room; drop loads outside the table
  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i && (is_eval || in_table);

  // Build the queued request
  always_comb begin
    req_o.is_eval = is_eval;
    req_o.addr    = ADDR_W'(int'(dim_select_i) * MAX_TERMS + int'(term_select_i));
    req_o.coeff   = coeff_value_i;
    if (x_value_i > X_ONE) begin
      req_o.x = X_ONE;
    end else if (x_value_i < X_NEG_ONE) begin
      req_o.x = X_NEG_ONE;
    end else begin
      req_o.x = x_value_i;
    end
  end

endmodule

### hdl/cse_queue.sv
// Short request queue between the front end and the evaluator.
module cse_queue import cse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cse_req_t req_i,
  output logic     ready_o,
  output logic     valid_o,
  output cse_req_t head_o,
  input  logic     pop_i
);

  `include "assert_macros.svh"

  cse_req_t            entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = QCNT_W'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = QCNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= req_i;
    end
  end

  `CSE_ASSERT(a_no_push_full, push_i |-> (count_q != QCNT_W'(QUEUE_DEPTH)), "push into full queue")
  `CSE_ASSERT_NR(a_no_pop_empty, pop_i |-> (count_q != '0), "pop from empty queue")

endmodule

### hdl/cse_back.sv
// Evaluator: runs the Chebyshev recurrence term by term and delivers one result per dimension.
module cse_back import cse_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cse_cfg_t                  cfg_i,
  input  logic                      req_valid_i,
  input  cse_req_t                  req_i,
  output logic                      pop_o,
  output logic                      ram_we_o,
  output logic [ADDR_W-1:0]         ram_waddr_o,
  output logic [COEFF_W-1:0]        ram_wdata_o,
  output logic [ADDR_W-1:0]         ram_raddr_o,
  input  logic [COEFF_W-1:0]        ram_rdata_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [DIM_W-1:0]          dim_out_o,
  output logic signed [COEFF_W-1:0] approx_value_o,
  output logic                      overflow_o,
  output logic                      last_o
);

  `include "assert_macros.svh"

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_LD   = 4'd2;
  localparam logic [3:0] ST_TN   = 4'd3;
  localparam logic [3:0] ST_TM   = 4'd4;
  localparam logic [3:0] ST_M1   = 4'd5;
  localparam logic [3:0] ST_M2   = 4'd6;
  localparam logic [3:0] ST_SUM  = 4'd7;
  localparam logic [3:0] ST_ACC  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]              state_q, state_d;
  logic [DCNT_W-1:0]       dim_q;
  logic [TCNT_W-1:0]       k_q;
  logic                    out_valid_q;

  logic signed [X_W-1:0]   x_q;
  logic [X_W-2:0]          x_mag_q;
  logic signed [X_W-1:0]   p0_q, p1_q, t_q;
  logic [X_W-1:0]          t_mag_q;
  logic [COEFF_W-1:0]      c_mag_q;
  logic                    c_neg_q;
  logic                    sign_q;
  logic [TWP_W-1:0]        prod2_q;
  logic [COEFF_W+HALF_W-1:0] hi_q, lo_q;
  logic [Q_W-1:0]          q_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [DIM_W-1:0]        dim_out_q;
  logic signed [COEFF_W-1:0] value_q;
  logic                    ovf_q;
  logic                    last_q;

  logic                    out_free;
  logic                    term_last;
  logic                    dim_last;
  logic                    k_zero;
  logic [X_W-1:0]          x_abs;
  logic [COEFF_W-1:0]      c_abs;
  logic signed [ACC_W-1:0] c_ext, c_contrib;
  logic [TWP_W-1:0]        tw_prod, tw_round;
  logic [TWM_W-1:0]        tw_mag;
  logic signed [TW_W-1:0]  tw_pos, tw_val, tw_diff;
  logic signed [X_W-1:0]   t_next;
  logic [X_W-1:0]          t_abs;
  logic [COEFF_W+HALF_W-1:0] hi_prod, lo_prod;
  logic [PROD_W-1:0]       p_sum;
  logic signed [ACC_W-1:0] q_ext, addend;
  logic [ACC_W-COEFF_W:0]  acc_top;
  logic                    acc_fits;
  logic signed [COEFF_W-1:0] acc_sat;

  // Handshake and loop conditions
  assign out_free  = !out_valid_q || out_ready_i;
  assign term_last = (TCNT_W'(k_q + 1'b1) == cfg_i.nt);
  assign dim_last  = (DCNT_W'(dim_q + 1'b1) == cfg_i.nd);
  assign k_zero    = (k_q == '0);

  // Take requests only between evaluations; a load writes the store at once
  assign pop_o       = (state_q == ST_IDLE) && req_valid_i;
  assign ram_we_o    = pop_o && !req_i.is_eval;
  assign ram_waddr_o = req_i.addr;
  assign ram_wdata_o = req_i.coeff;
  assign ram_raddr_o = ADDR_W'(int'(dim_q) * MAX_TERMS + int'(k_q));

  // Magnitudes of x and of the fetched coefficient
  assign x_abs = req_i.x[X_W-1] ? (~req_i.x + 1'b1) : req_i.x;
  assign c_abs = ram_rdata_i[COEFF_W-1] ? (~ram_rdata_i + 1'b1) : ram_rdata_i;

  // Constant term: c0 less its floored half
  assign c_ext     = {{(ACC_W-COEFF_W){ram_rdata_i[COEFF_W-1]}}, ram_rdata_i};
  assign c_contrib = c_ext - (c_ext >>> 1);

  // Recurrence: round 2xT to nearest, ties away from zero, subtract the older term, clamp
  assign tw_prod  = x_mag_q * t_mag_q;
  assign tw_round = prod2_q + (TWP_W'(1) << (FRAC_W - 2));
  assign tw_mag   = tw_round[TWP_W-1:FRAC_W-1];
  assign tw_pos   = $signed({{(TW_W-TWM_W){1'b0}}, tw_mag});
  assign tw_val   = (x_q[X_W-1] ^ p1_q[X_W-1]) ? -tw_pos : tw_pos;
  assign tw_diff  = tw_val - {{(TW_W-X_W){p0_q[X_W-1]}}, p0_q};

  always_comb begin
    if ((&tw_diff[TW_W-1:X_W-1]) || !(|tw_diff[TW_W-1:X_W-1])) begin
      t_next = tw_diff[X_W-1:0];
    end else if (tw_diff[TW_W-1]) begin
      t_next = {1'b1, {(X_W-1){1'b0}}};
    end else begin
      t_next = {1'b0, {(X_W-1){1'b1}}};
    end
  end

  assign t_abs = t_q[X_W-1] ? (~t_q + 1'b1) : t_q;

  // Coefficient product in two halves of |T|, then round and accumulate
  assign hi_prod = c_mag_q * t_mag_q[X_W-1:HALF_W];
  assign lo_prod = c_mag_q * t_mag_q[HALF_W-1:0];
  assign p_sum   = {hi_q, {HALF_W{1'b0}}} + PROD_W'(lo_q) + (PROD_W'(1) << (FRAC_W - 1));
  assign q_ext   = $signed({{(ACC_W-Q_W){1'b0}}, q_q});
  assign addend  = sign_q ? -q_ext : q_ext;

  // Saturate the sum to the result width
  assign acc_top  = acc_q[ACC_W-1:COEFF_W-1];
  assign acc_fits = (&acc_top) || !(|acc_top);

  always_comb begin
    if (acc_fits) begin
      acc_sat = acc_q[COEFF_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      acc_sat = {1'b1, {(COEFF_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(COEFF_W-1){1'b1}}};
    end
  end

  // Sequence the steps of each term
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && req_i.is_eval) begin
          state_d = ST_RD;
        end
      end
      ST_RD:  state_d = ST_LD;
      ST_LD: begin
        if (!k_zero) begin
          state_d = ST_TN;
        end else if (cfg_i.nt == TCNT_W'(1)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_TN:  state_d = ST_TM;
      ST_TM:  state_d = ST_M1;
      ST_M1:  state_d = ST_M2;
      ST_M2:  state_d = ST_SUM;
      ST_SUM: state_d = ST_ACC;
      ST_ACC: state_d = term_last ? ST_OUT : ST_RD;
      ST_OUT: begin
        if (out_free) begin
          state_d = dim_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the state, the loop counters and the result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dim_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o && req_i.is_eval) begin
        dim_q <= '0;
        k_q   <= '0;
      end else if (state_q == ST_LD && k_zero) begin
        k_q <= TCNT_W'(1);
      end else if (state_q == ST_ACC && !term_last) begin
        k_q <= TCNT_W'(k_q + 1'b1);
      end else if (state_q == ST_OUT && out_free && !dim_last) begin
        dim_q <= DCNT_W'(dim_q + 1'b1);
        k_q   <= '0;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o && req_i.is_eval) begin
      x_q     <= req_i.x;
      x_mag_q <= x_abs[X_W-2:0];
    end
    if (state_q == ST_LD) begin
      if (k_zero) begin
        acc_q <= c_contrib;
      end
      c_mag_q <= c_abs;
      c_neg_q <= ram_rdata_i[COEFF_W-1];
      prod2_q <= tw_prod;
    end
    if (state_q == ST_TN) begin
      if (k_q == TCNT_W'(1)) begin
        t_q  <= x_q;
        p0_q <= X_ONE;
        p1_q <= x_q;
      end else begin
        t_q  <= t_next;
        p0_q <= p1_q;
        p1_q <= t_next;
      end
    end
    if (state_q == ST_TM) begin
      t_mag_q <= t_abs;
      sign_q  <= c_neg_q ^ t_q[X_W-1];
    end
    if (state_q == ST_M1) begin
      hi_q <= hi_prod;
    end
    if (state_q == ST_M2) begin
      lo_q <= lo_prod;
    end
    if (state_q == ST_SUM) begin
      q_q <= p_sum[PROD_W-1:FRAC_W];
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_q + addend;
    end
    if (state_q == ST_OUT && out_free) begin
      dim_out_q <= DIM_W'(dim_q);
      value_q   <= acc_sat;
      ovf_q     <= !acc_fits;
      last_q    <= dim_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dim_out_o      = dim_out_q;
  assign approx_value_o = value_q;
  assign overflow_o     = ovf_q;
  assign last_o         = last_q;

  `CSE_ASSERT(a_we_idle, ram_we_o |-> (state_q == ST_IDLE), "store written mid evaluation")
  `CSE_ASSERT(a_rd_in_range, (state_q == ST_RD) |-> (k_q < cfg_i.nt), "term index past count")
  `CSE_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> ($past(state_q) == ST_OUT), "stray result")

endmodule

### hdl/chebyshev_series_eval_top.sv
// Top level of the Chebyshev series evaluator: configuration, front end, queue, store, evaluator.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------------
//  in      | request   | in_valid_i/ready_o   | command, dim_select, term_select, coeff, x
//  cfg     | write     | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//  out     | result    | out_valid_o/ready_i  | dim_out, approx_value, overflow, last
//
// A load writes the store as the evaluator takes it from the queue. In an evaluation each
// term after the first is eight steps of the shared sequencer (store read, recurrence
// multiply, T, |T|, two 48x16 halves, rounding, accumulate), and each dimension ends with
// a step into the result register.
// A two-entry queue lets new requests in while an evaluation runs.
// Reset clears the configuration to one term and one dimension; the store is left as is.
// A stalled result holds the evaluator only in its final step for that dimension.
module chebyshev_series_eval_top import cse_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [DIM_W-1:0]          dim_select_i,
  input  logic [TERM_W-1:0]         term_select_i,
  input  logic signed [COEFF_W-1:0] coeff_value_i,
  input  logic signed [X_W-1:0]     x_value_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [DIM_W-1:0]          dim_out_o,
  output logic signed [COEFF_W-1:0] approx_value_o,
  output logic                      overflow_o,
  output logic                      last_o
);

  logic [NUM_TERMS_W-1:0] num_terms_q;
  logic [NUM_DIMS_W-1:0]  num_dims_q;
  cse_cfg_t               cfg;

  logic                   push;
  cse_req_t               push_req;
  logic                   q_ready;
  logic                   q_valid;
  cse_req_t               q_head;
  logic                   pop;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [COEFF_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [COEFF_W-1:0]     ram_rdata;

  // Write configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_terms_q <= NUM_TERMS_W'(1);
      num_dims_q  <= NUM_DIMS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NUM_TERMS: num_terms_q <= cfg_data_i[NUM_TERMS_W-1:0];
        CFG_NUM_DIMS:  num_dims_q  <= cfg_data_i[NUM_DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts to the supported range
  always_comb begin
    if (num_terms_q == '0) begin
      cfg.nt = TCNT_W'(1);
    end else if (int'(num_terms_q) > MAX_TERMS) begin
      cfg.nt = TCNT_W'(MAX_TERMS);
    end else begin
      cfg.nt = TCNT_W'(num_terms_q);
    end
    if (num_dims_q == '0) begin
      cfg.nd = DCNT_W'(1);
    end else if (int'(num_dims_q) > MAX_DIMS) begin
      cfg.nd = DCNT_W'(MAX_DIMS);
    end else begin
      cfg.nd = DCNT_W'(num_dims_q);
    end
  end

  cse_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .dim_select_i  (dim_select_i),
    .term_select_i (term_select_i),
    .coeff_value_i (coeff_value_i),
    .x_value_i     (x_value_i),
    .push_o        (push),
    .req_o         (push_req),
    .q_ready_i     (q_ready)
  );

  cse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (pop)
  );

  cse_ram #(
    .WIDTH (COEFF_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cse_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .req_valid_i    (q_valid),
    .req_i          (q_head),
    .pop_o          (pop),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dim_out_o      (dim_out_o),
    .approx_value_o (approx_value_o),
    .overflow_o     (overflow_o),
    .last_o         (last_o)
  );

endmodule
